@@ hdl/address_claim_responder_unit_assert.svh @@
// Assertion macros for the address claim responder.
`ifndef ADDRESS_CLAIM_RESPONDER_UNIT_ASSERT_SVH
`define ADDRESS_CLAIM_RESPONDER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clock, disabled in reset.
`define ACR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on clock, disabled in reset.
`define ACR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ACR_ASSERT_NOW(label, ante, cons, msg)
`define ACR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ hdl/acr_pkg.sv @@
// Types and constants shared by the address claim responder.
package acr_pkg;

   localparam logic [1:0] CMD_INITIAL_CLAIM = 2'd0;
   localparam logic [1:0] CMD_REQUEST_CLAIM = 2'd1;
   localparam logic [1:0] CMD_COMPETING     = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_TX   = 2'd1;
   localparam logic [1:0] ST_NO_ADDR = 2'd2;

   localparam logic CSR_OWN_NAME    = 1'b0;
   localparam logic CSR_OWN_ADDRESS = 1'b1;

   localparam logic [2:0] PRIO_CLAIM      = 3'd6;
   localparam logic [7:0] PF_ADDR_CLAIMED = 8'd238;
   localparam logic [7:0] PS_GLOBAL       = 8'd255;
   localparam logic [7:0] ADDR_NULL       = 8'd254;
   localparam logic [7:0] TIMER_TICKS     = 8'd250;
   localparam logic [7:0] ADDR_HIGH_BIT   = 8'h80;
   localparam logic [7:0] ADDR_FREE_LOW   = 8'hF8;
   localparam logic [7:0] ADDR_FREE_HIGH  = 8'hFD;

   typedef struct packed {
      logic       cannot_claim;
      logic       waiting_contention;
      logic       timer_enabled;
      logic [7:0] timer_load;
      logic       release_flag;
   } acr_state_type;

   typedef struct packed {
      logic        frame_valid;
      logic [2:0]  frame_priority;
      logic [7:0]  frame_pdu_format;
      logic [7:0]  frame_pdu_specific;
      logic [7:0]  frame_source;
      logic [63:0] frame_data;
      logic [1:0]  status;
      logic        cannot_claim_now;
      logic        waiting_now;
      logic        timer_start;
      logic        release_now;
   } acr_result_type;

endpackage

@@ hdl/acr_req_if.sv @@
// Event channel into the address claim responder.
interface acr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [63:0] other_name;
   logic        tx_accepted;

   modport source (output valid, output command, output other_name, output tx_accepted,
                   input ready);
   modport sink (input valid, input command, input other_name, input tx_accepted,
                 output ready);
endinterface

@@ hdl/acr_rsp_if.sv @@
// Result channel out of the address claim responder.
interface acr_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_valid;
   logic [2:0]  frame_priority;
   logic [7:0]  frame_pdu_format;
   logic [7:0]  frame_pdu_specific;
   logic [7:0]  frame_source;
   logic [63:0] frame_data;
   logic [1:0]  status;
   logic        cannot_claim_now;
   logic        waiting_now;
   logic        timer_start;
   logic        release_now;

   modport source (output valid, output frame_valid, output frame_priority,
                   output frame_pdu_format, output frame_pdu_specific, output frame_source,
                   output frame_data, output status, output cannot_claim_now,
                   output waiting_now, output timer_start, output release_now,
                   input ready);
   modport sink (input valid, input frame_valid, input frame_priority,
                 input frame_pdu_format, input frame_pdu_specific, input frame_source,
                 input frame_data, input status, input cannot_claim_now,
                 input waiting_now, input timer_start, input release_now,
                 output ready);
endinterface

@@ hdl/acr_claim_core.sv @@
// Claim decision logic: result word and next node state for one event.
module acr_claim_core (
   input  logic [1:0]             command,
   input  logic [63:0]            other_name,
   input  logic                   tx_accepted,
   input  logic [63:0]            own_name,
   input  logic [7:0]             own_address,
   input  acr_pkg::acr_state_type state_cur,
   output acr_pkg::acr_state_type state_nxt,
   output acr_pkg::acr_result_type result
);

   // Byte 0 decides first, so put it in the most significant place.
   function automatic logic [63:0] byte_rev(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) begin
         r[8*(7-i) +: 8] = v[8*i +: 8];
      end
      return r;
   endfunction

   logic       name_lower;
   logic       addr_free;
   logic       valid;
   logic [7:0] src;
   logic [1:0] status;
   logic       tstart;

   assign name_lower = byte_rev(own_name) < byte_rev(other_name);
   assign addr_free  = ((own_address & acr_pkg::ADDR_HIGH_BIT) == 8'd0) ||
                       ((own_address >= acr_pkg::ADDR_FREE_LOW) &&
                        (own_address <= acr_pkg::ADDR_FREE_HIGH));

   always_comb begin
      state_nxt = state_cur;
      valid     = 1'b0;
      src       = 8'd0;
      status    = acr_pkg::ST_OK;
      tstart    = 1'b0;
      case (command)
         acr_pkg::CMD_INITIAL_CLAIM: begin
            if (own_address == acr_pkg::ADDR_NULL) begin
               status = acr_pkg::ST_NO_ADDR;
            end else begin
               state_nxt.cannot_claim = 1'b1;
               valid = 1'b1;
               src   = own_address;
               if (tx_accepted) begin
                  tstart = 1'b1;
               end else begin
                  status = acr_pkg::ST_NO_TX;
               end
            end
         end
         acr_pkg::CMD_REQUEST_CLAIM: begin
            valid = 1'b1;
            src   = state_cur.cannot_claim ? acr_pkg::ADDR_NULL : own_address;
            if (!tx_accepted) begin
               status = acr_pkg::ST_NO_TX;
            end
         end
         acr_pkg::CMD_COMPETING: begin
            valid = 1'b1;
            if (!name_lower) begin
               src = acr_pkg::ADDR_NULL;
               if (tx_accepted) begin
                  state_nxt.release_flag = 1'b1;
               end else begin
                  status = acr_pkg::ST_NO_TX;
               end
            end else begin
               src = own_address;
               if (!tx_accepted) begin
                  status = acr_pkg::ST_NO_TX;
               end else if (addr_free) begin
                  state_nxt.cannot_claim = 1'b0;
               end else begin
                  tstart = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      if (tstart) begin
         state_nxt.waiting_contention = 1'b1;
         state_nxt.timer_load         = acr_pkg::TIMER_TICKS;
         state_nxt.timer_enabled      = 1'b1;
         state_nxt.release_flag       = 1'b0;
      end
   end

   always_comb begin
      result.frame_valid        = valid;
      result.frame_priority     = valid ? acr_pkg::PRIO_CLAIM : 3'd0;
      result.frame_pdu_format   = valid ? acr_pkg::PF_ADDR_CLAIMED : 8'd0;
      result.frame_pdu_specific = valid ? acr_pkg::PS_GLOBAL : 8'd0;
      result.frame_source       = valid ? src : 8'd0;
      result.frame_data         = valid ? own_name : 64'd0;
      result.status             = status;
      result.cannot_claim_now   = state_nxt.cannot_claim;
      result.waiting_now        = state_nxt.waiting_contention;
      result.timer_start        = tstart;
      result.release_now        = state_nxt.release_flag;
   end

endmodule

@@ hdl/address_claim_responder_unit.sv @@
// Top level of the J1939 address claim responder.
// Path: an accepted word is held in the input register, decided from it, and shows on
// rsp_ch from the result register, where it stays until rsp_ch takes it.
// Throughput: one event word per cycle while rsp_ch is ready; while a result word waits,
// the input register takes at most one more word and then holds req_ch.ready low.
// Reset (synchronous, active high): flags to cannot-claim set, others clear; own_name 0,
// own_address 254; both pipeline stages empty.
`include "address_claim_responder_unit_assert.svh"

module address_claim_responder_unit (
   input  logic        clock,
   input  logic        reset,
   acr_req_if.sink     req_ch,
   acr_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   // Configuration registers.
   logic [63:0] own_name_ff,    own_name_in;
   logic [7:0]  own_address_ff, own_address_in;

   // Input stage: holds one event word.
   logic        s1_valid_ff,   s1_valid_in;
   logic [1:0]  s1_command_ff, s1_command_in;
   logic [63:0] s1_other_ff,   s1_other_in;
   logic        s1_acc_ff,     s1_acc_in;

   // Result stage: holds one result word.
   logic                    s2_valid_ff, s2_valid_in;
   acr_pkg::acr_result_type s2_result_ff, s2_result_in;

   // Node state.
   acr_pkg::acr_state_type state_ff, state_in;
   acr_pkg::acr_state_type state_nxt;
   acr_pkg::acr_result_type core_result;

   logic req_fire;
   logic s2_load;
   logic s1_fire;

   // Result stage frees when empty or when its word is taken this cycle.
   assign s2_load      = !s2_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && s2_load;
   assign req_ch.ready = !s1_valid_ff || s2_load;
   assign req_fire     = req_ch.valid && req_ch.ready;

   acr_claim_core u_core (
      .command     (s1_command_ff),
      .other_name  (s1_other_ff),
      .tx_accepted (s1_acc_ff),
      .own_name    (own_name_ff),
      .own_address (own_address_ff),
      .state_cur   (state_ff),
      .state_nxt   (state_nxt),
      .result      (core_result)
   );

   always_comb begin
      // Write configuration only when the index matches.
      own_name_in    = own_name_ff;
      own_address_in = own_address_ff;
      if (csr_we) begin
         case (csr_index)
            acr_pkg::CSR_OWN_NAME:    own_name_in    = csr_wdata;
            acr_pkg::CSR_OWN_ADDRESS: own_address_in = csr_wdata[7:0];
            default: begin
            end
         endcase
      end

      // Load the input stage on a new word, drop it when it moves on.
      s1_valid_in   = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s1_command_in = req_fire ? req_ch.command     : s1_command_ff;
      s1_other_in   = req_fire ? req_ch.other_name  : s1_other_ff;
      s1_acc_in     = req_fire ? req_ch.tx_accepted : s1_acc_ff;

      // Advance the decision into the result stage; hold it while stalled.
      s2_valid_in  = s1_fire ? 1'b1 : (s2_valid_ff && !rsp_ch.ready);
      s2_result_in = s1_fire ? core_result : s2_result_ff;

      // Commit the node state only as the event leaves the input stage, so the
      // next word sees it.
      state_in = s1_fire ? state_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_name_ff                 <= 64'd0;
         own_address_ff              <= acr_pkg::ADDR_NULL;
         s1_valid_ff                 <= 1'b0;
         s2_valid_ff                 <= 1'b0;
         state_ff.cannot_claim       <= 1'b1;
         state_ff.waiting_contention <= 1'b0;
         state_ff.timer_enabled      <= 1'b0;
         state_ff.timer_load         <= 8'd0;
         state_ff.release_flag       <= 1'b0;
      end else begin
         own_name_ff    <= own_name_in;
         own_address_ff <= own_address_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         state_ff       <= state_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      s1_command_ff <= s1_command_in;
      s1_other_ff   <= s1_other_in;
      s1_acc_ff     <= s1_acc_in;
      s2_result_ff  <= s2_result_in;
   end

   assign rsp_ch.valid              = s2_valid_ff;
   assign rsp_ch.frame_valid        = s2_result_ff.frame_valid;
   assign rsp_ch.frame_priority     = s2_result_ff.frame_priority;
   assign rsp_ch.frame_pdu_format   = s2_result_ff.frame_pdu_format;
   assign rsp_ch.frame_pdu_specific = s2_result_ff.frame_pdu_specific;
   assign rsp_ch.frame_source       = s2_result_ff.frame_source;
   assign rsp_ch.frame_data         = s2_result_ff.frame_data;
   assign rsp_ch.status             = s2_result_ff.status;
   assign rsp_ch.cannot_claim_now   = s2_result_ff.cannot_claim_now;
   assign rsp_ch.waiting_now        = s2_result_ff.waiting_now;
   assign rsp_ch.timer_start        = s2_result_ff.timer_start;
   assign rsp_ch.release_now        = s2_result_ff.release_now;

   `ACR_ASSERT_NOW(a_timer_flags, rsp_ch.valid && rsp_ch.timer_start, rsp_ch.waiting_now && !rsp_ch.release_now, "timer start without waiting set and release clear")
   `ACR_ASSERT_NOW(a_no_addr_quiet, rsp_ch.valid && (rsp_ch.status == acr_pkg::ST_NO_ADDR), !rsp_ch.frame_valid && !rsp_ch.timer_start, "frame or timer on a missing address")
   `ACR_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !s2_load, s1_valid_ff, "input stage word lost under stall")
   `ACR_ASSERT_NEXT(a_state_quiet, !s1_fire, $stable(state_ff), "node state moved without an event")

endmodule
